// ----- rtl/recursive_matmul_address_trace_macros.svh -----
// Assertion macros for the recursive matrix multiply address trace block.
// Included by the top level; no other dependencies.
`ifndef RECURSIVE_MATMUL_ADDRESS_TRACE_MACROS_SVH
`define RECURSIVE_MATMUL_ADDRESS_TRACE_MACROS_SVH

// same-cycle implication
`define RMAT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rmat_pkg.sv -----
// Shared types, constants and elaboration helpers for the address trace block.
// No dependencies.
`default_nettype none

package rmat_pkg;

  localparam int unsigned SideW   = 11;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned SelW    = 2;

  localparam int unsigned DefMaxSide      = 1024;
  localparam int unsigned DefLeafLimit    = 8;
  localparam int unsigned DefElementBytes = 4;

  localparam logic [SideW-1:0] SideReset = SideW'(8);

  localparam logic [CfgIdxW-1:0] RegSide  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegABase = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegBBase = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegCBase = CfgIdxW'(3);

  typedef enum logic [SelW-1:0] {
    MAT_A = 2'd0,
    MAT_B = 2'd1,
    MAT_C = 2'd2
  } mat_sel_e;

  typedef struct packed {
    logic     rewind;
    logic     finish;
    logic     init_accum;
    logic     accum_step;
    logic     mul;
    logic     load_out;
    logic     advance;
    mat_sel_e sel;
  } rmat_cmd_t;

  typedef struct packed {
    logic finished;
    logic zero_side;
    logic levels_done;
    logic out_full;
  } rmat_stat_t;

  function automatic int unsigned split_levels(int unsigned side, int unsigned leaf_limit);
    int unsigned n;
    int unsigned d;
    n = side;
    d = 0;
    while (n > leaf_limit) begin
      n = n >> 1;
      d = d + 1;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rmat_ctrl.sv -----
// Sequencer for the address trace: accept, check, level walk, three accesses.
// Depends on rmat_pkg.
`default_nettype none

module rmat_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   restart_i,
  output logic                   in_ready_o,
  input  rmat_pkg::rmat_stat_t   stat_i,
  output rmat_pkg::rmat_cmd_t    cmd_o
);
  import rmat_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ACCUM = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;

  logic [2:0] state_q, state_d;
  mat_sel_e   sel_q, sel_d;

  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    cmd_o      = '0;
    cmd_o.sel  = sel_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.rewind = restart_i;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.finished) begin
          state_d = S_IDLE;
        end else if (stat_i.zero_side) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.init_accum = 1'b1;
          state_d          = S_ACCUM;
        end
      end
      S_ACCUM: begin
        if (stat_i.levels_done) begin
          state_d = S_MUL;
        end else begin
          cmd_o.accum_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_LOAD;
      end
      S_LOAD: begin
        if (!stat_i.out_full) begin
          cmd_o.load_out = 1'b1;
          if (sel_q == MAT_C) begin
            cmd_o.advance = 1'b1;
            sel_d         = MAT_A;
            state_d       = S_IDLE;
          end else begin
            sel_d   = (sel_q == MAT_A) ? MAT_B : MAT_C;
            state_d = S_MUL;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
        sel_d   = MAT_A;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= MAT_A;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rmat_dp.sv -----
// Datapath: configuration registers, walk position, coordinate accumulation,
// address multiply and the output register. Depends on rmat_pkg.
`default_nettype none

module rmat_dp #(
  parameter int unsigned MAX_SIDE      = rmat_pkg::DefMaxSide,
  parameter int unsigned LEAF_LIMIT    = rmat_pkg::DefLeafLimit,
  parameter int unsigned ELEMENT_BYTES = rmat_pkg::DefElementBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rmat_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rmat_pkg::AddrW-1:0]    cfg_data_i,
  input  rmat_pkg::rmat_cmd_t           cmd_i,
  output rmat_pkg::rmat_stat_t          stat_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [rmat_pkg::AddrW-1:0]    byte_address_o,
  output logic [rmat_pkg::SelW-1:0]     matrix_select_o,
  output logic                          last_of_point_o,
  output logic                          end_of_trace_o,
  output logic                          unsupported_side_o
);
  import rmat_pkg::*;

  localparam int unsigned MaxLevels = split_levels(2**SideW - 1, LEAF_LIMIT);
  localparam int unsigned TileW     = 3 * MaxLevels;
  localparam int unsigned LvlW      = $clog2(MaxLevels + 1);
  localparam int unsigned ShW       = LvlW + 2;
  localparam int unsigned LeafW     = $clog2(LEAF_LIMIT + 1);
  localparam int unsigned PosW      = (LEAF_LIMIT > 1) ? $clog2(LEAF_LIMIT) : 1;
  localparam int unsigned PW        = LeafW + 1;
  localparam int unsigned ProdW     = 2 * SideW;

  logic [SideW-1:0] side_q;
  logic [AddrW-1:0] a_base_q, b_base_q, c_base_q;

  logic [TileW-1:0] tile_q;
  logic [PosW-1:0]  row_q, col_q, inner_q;
  logic             finished_q;

  logic [SideW-1:0] ri_q, cj_q, rk_q, half_q;
  logic [TileW-1:0] digits_q;
  logic [LvlW-1:0]  lvl_q;
  logic [ProdW-1:0] prod_q;

  logic             out_valid_q;
  logic [AddrW-1:0] addr_q;
  mat_sel_e         out_sel_q;
  logic             last_q, end_q, flag_q;

  logic [LvlW-1:0]  levels;
  logic             bad;
  logic [LeafW-1:0] leaf;
  logic [ShW-1:0]   tile_sh, dig_sh;
  logic [TileW-1:0] last_tile;
  logic             is_last;
  logic             row_end, col_end, inner_end;
  logic [2:0]       digit;
  logic [SideW-1:0] mul_row, mul_col;
  logic [AddrW-1:0] base_sel;

  always_comb begin
    levels = '0;
    bad    = 1'b0;
    for (int s = 0; s < MaxLevels; s++) begin
      if ((side_q >> s) > SideW'(LEAF_LIMIT)) begin
        levels = levels + LvlW'(1);
        if (side_q[s]) begin
          bad = 1'b1;
        end
      end
    end
    if (32'(side_q) > 32'(MAX_SIDE)) begin
      bad = 1'b1;
    end
  end

  assign leaf      = LeafW'(side_q >> levels);
  assign tile_sh   = ShW'(levels) * ShW'(3);
  assign dig_sh    = ShW'(LvlW'(MaxLevels) - levels) * ShW'(3);
  assign last_tile = ~({TileW{1'b1}} << tile_sh);

  assign row_end   = (PW'(row_q) + PW'(1)) == PW'(leaf);
  assign col_end   = (PW'(col_q) + PW'(1)) == PW'(leaf);
  assign inner_end = (PW'(inner_q) + PW'(1)) == PW'(leaf);
  assign is_last   = (tile_q == last_tile) && row_end && col_end && inner_end;

  assign digit = digits_q[TileW-1 -: 3];

  always_comb begin
    case (cmd_i.sel)
      MAT_A: begin
        mul_row  = ri_q;
        mul_col  = rk_q;
        base_sel = a_base_q;
      end
      MAT_B: begin
        mul_row  = rk_q;
        mul_col  = cj_q;
        base_sel = b_base_q;
      end
      MAT_C: begin
        mul_row  = ri_q;
        mul_col  = cj_q;
        base_sel = c_base_q;
      end
      default: begin
        mul_row  = '0;
        mul_col  = '0;
        base_sel = '0;
      end
    endcase
  end

  // configuration and walk position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q     <= SideReset;
      a_base_q   <= '0;
      b_base_q   <= '0;
      c_base_q   <= '0;
      tile_q     <= '0;
      row_q      <= '0;
      col_q      <= '0;
      inner_q    <= '0;
      finished_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegSide:  side_q   <= cfg_data_i[SideW-1:0];
          RegABase: a_base_q <= cfg_data_i;
          RegBBase: b_base_q <= cfg_data_i;
          RegCBase: c_base_q <= cfg_data_i;
          default:  ;
        endcase
      end
      if (cfg_we_i || cmd_i.rewind) begin
        tile_q     <= '0;
        row_q      <= '0;
        col_q      <= '0;
        inner_q    <= '0;
        finished_q <= 1'b0;
      end else if (cmd_i.finish) begin
        finished_q <= 1'b1;
      end else if (cmd_i.advance) begin
        if (is_last) begin
          finished_q <= 1'b1;
        end else if (!inner_end) begin
          inner_q <= inner_q + PosW'(1);
        end else begin
          inner_q <= '0;
          if (!col_end) begin
            col_q <= col_q + PosW'(1);
          end else begin
            col_q <= '0;
            if (!row_end) begin
              row_q <= row_q + PosW'(1);
            end else begin
              row_q  <= '0;
              tile_q <= tile_q + TileW'(1);
            end
          end
        end
      end
    end
  end

  // coordinate accumulation, one level a cycle, and the address product
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_accum) begin
      ri_q     <= SideW'(row_q);
      cj_q     <= SideW'(col_q);
      rk_q     <= SideW'(inner_q);
      half_q   <= side_q >> 1;
      digits_q <= tile_q << dig_sh;
      lvl_q    <= '0;
    end else if (cmd_i.accum_step) begin
      if (digit[2]) begin
        ri_q <= ri_q + half_q;
      end
      if (digit[1]) begin
        cj_q <= cj_q + half_q;
      end
      if (digit[0]) begin
        rk_q <= rk_q + half_q;
      end
      half_q   <= half_q >> 1;
      digits_q <= digits_q << 3;
      lvl_q    <= lvl_q + LvlW'(1);
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(mul_row) * ProdW'(side_q) + ProdW'(mul_col);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      addr_q    <= base_sel + AddrW'(prod_q) * AddrW'(ELEMENT_BYTES);
      out_sel_q <= cmd_i.sel;
      last_q    <= cmd_i.sel == MAT_C;
      end_q     <= (cmd_i.sel == MAT_C) && is_last;
      flag_q    <= bad;
    end
  end

  assign stat_o.finished    = finished_q;
  assign stat_o.zero_side   = side_q == '0;
  assign stat_o.levels_done = lvl_q == levels;
  assign stat_o.out_full    = out_valid_q && !out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign byte_address_o     = addr_q;
  assign matrix_select_o    = out_sel_q;
  assign last_of_point_o    = last_q;
  assign end_of_trace_o     = end_q;
  assign unsupported_side_o = flag_q;

endmodule

`default_nettype wire

// ----- rtl/recursive_matmul_address_trace.sv -----
// Top level of the recursive matrix multiply address trace generator.
// Depends on rmat_pkg, rmat_ctrl, rmat_dp and the assertion macro header.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, restart_i): each transaction asks
//   for the next (i,j,k) point, or with restart_i high for the first point.
//   Output channel (out_valid_o/out_ready_i): a point yields three
//   transactions, A then B then C; the C one carries last_of_point_o and,
//   on the final point, end_of_trace_o. After the end, or with side zero,
//   a request yields nothing.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i;
//   any write returns the walk to the first point.
//   Timing: the time from acceptance until ready returns, and so per point,
//   grows with d, d being the number of halvings of the side down to the leaf
//   (at most 8); it is set by the level-per-cycle coordinate walk and the single
//   multiply-and-add unit shared by the three accesses.
//   Stall: a waiting result holds in the output register and the sequencer
//   waits; nothing is dropped.
//   Reset: side 8, bases zero, walk at the first point, no result pending.
`default_nettype none
`include "recursive_matmul_address_trace_macros.svh"

module recursive_matmul_address_trace #(
  parameter int unsigned MAX_SIDE      = rmat_pkg::DefMaxSide,
  parameter int unsigned LEAF_LIMIT    = rmat_pkg::DefLeafLimit,
  parameter int unsigned ELEMENT_BYTES = rmat_pkg::DefElementBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rmat_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rmat_pkg::AddrW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rmat_pkg::AddrW-1:0]    byte_address_o,
  output logic [rmat_pkg::SelW-1:0]     matrix_select_o,
  output logic                          last_of_point_o,
  output logic                          end_of_trace_o,
  output logic                          unsupported_side_o
);
  import rmat_pkg::*;

  rmat_cmd_t  cmd;
  rmat_stat_t stat;

  rmat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rmat_dp #(
    .MAX_SIDE      (MAX_SIDE),
    .LEAF_LIMIT    (LEAF_LIMIT),
    .ELEMENT_BYTES (ELEMENT_BYTES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .byte_address_o     (byte_address_o),
    .matrix_select_o    (matrix_select_o),
    .last_of_point_o    (last_of_point_o),
    .end_of_trace_o     (end_of_trace_o),
    .unsupported_side_o (unsupported_side_o)
  );

  `RMAT_ASSERT_IMPLY(a_last_on_c, clk_i, rst_ni, out_valid_o,
                    last_of_point_o == (matrix_select_o == MAT_C),
                    "last flag not on the C access")
  `RMAT_ASSERT_IMPLY(a_end_is_last, clk_i, rst_ni, out_valid_o && end_of_trace_o,
                    last_of_point_o, "end of trace off a point end")
  `RMAT_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o,
                   !in_ready_o, "ready held after a transaction")

endmodule

`default_nettype wire

// ----- verif/tb_recursive_matmul_address_trace.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the recursive matrix multiply address trace generator.
// Depends on rmat_pkg and recursive_matmul_address_trace; a scoreboard class predicts
// every A, B and C access and checks the output transactions in order.

module tb_recursive_matmul_address_trace;
  import rmat_pkg::*;

  localparam int unsigned    LeafLimit    = DefLeafLimit;
  localparam int unsigned    MaxSide      = DefMaxSide;
  localparam int unsigned    ElemBytes    = DefElementBytes;
  localparam logic [CfgIdxW-1:0] RegNone  = CfgIdxW'(255);
  localparam int unsigned    SettleCycles = 40;
  localparam int unsigned    CycleLimit   = 200000;
  localparam int unsigned    SegmentItems = 13;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [SelW-1:0]  sel;
    logic             last;
    logic             eot;
    logic             unsup;
  } access_t;

  class trace_scoreboard;
    logic [SideW-1:0]  side;
    logic [AddrW-1:0]  base_a;
    logic [AddrW-1:0]  base_b;
    logic [AddrW-1:0]  base_c;
    longint unsigned   tile_idx;
    int unsigned       row;
    int unsigned       col;
    int unsigned       inner;
    bit                done;
    access_t           expected_q[$];
    int unsigned       errors;
    int unsigned       points;
    int unsigned       traces;
    int unsigned       accesses;

    function new();
      side     = SideReset;
      base_a   = '0;
      base_b   = '0;
      base_c   = '0;
      errors   = 0;
      points   = 0;
      traces   = 0;
      accesses = 0;
      rewind();
    endfunction

    function void rewind();
      tile_idx = 0;
      row      = 0;
      col      = 0;
      inner    = 0;
      done     = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [AddrW-1:0] data);
      case (idx)
        RegSide:  side   = data[SideW-1:0];
        RegABase: base_a = data;
        RegBBase: base_b = data;
        RegCBase: base_c = data;
        default: ;
      endcase
      rewind();
    endfunction

    function bit trace_done();
      return done;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function logic [AddrW-1:0] elem_addr(logic [AddrW-1:0] base, longint unsigned r,
                                         longint unsigned c);
      longint unsigned n;
      longint unsigned off;
      n   = side;
      off = (r * n + c) * ElemBytes;
      return base + off[AddrW-1:0];
    endfunction

    function int unsigned note_request(bit restart);
      longint unsigned n;
      longint unsigned m;
      longint unsigned h;
      longint unsigned ri;
      longint unsigned cj;
      longint unsigned rk;
      longint unsigned digit;
      longint unsigned last_tile;
      int unsigned     depth;
      int unsigned     leaf;
      int unsigned     lvl;
      bit              bad;
      bit              is_last;
      access_t         acc;
      if (restart) rewind();
      if (done) return 0;
      n = side;
      if (n == 0) begin
        done = 1'b1;
        return 0;
      end
      depth = 0;
      bad   = 1'b0;
      m     = n;
      while (m > LeafLimit) begin
        if ((m & 1) != 0) bad = 1'b1;
        m = m >> 1;
        depth++;
      end
      if (n > MaxSide) bad = 1'b1;
      leaf = int'(m);
      ri = row;
      cj = col;
      rk = inner;
      for (lvl = 0; lvl < depth; lvl++) begin
        digit = (tile_idx >> (3 * (depth - 1 - lvl))) & 7;
        h     = n >> (lvl + 1);
        if ((digit & 4) != 0) ri += h;
        if ((digit & 2) != 0) cj += h;
        if ((digit & 1) != 0) rk += h;
      end
      last_tile = (64'd1 << (3 * depth)) - 1;
      is_last = (tile_idx == last_tile) && (row == leaf - 1) && (col == leaf - 1) &&
                (inner == leaf - 1);

      acc.unsup = bad;
      acc.addr  = elem_addr(base_a, ri, rk);
      acc.sel   = MAT_A;
      acc.last  = 1'b0;
      acc.eot   = 1'b0;
      expected_q.push_back(acc);
      acc.addr  = elem_addr(base_b, rk, cj);
      acc.sel   = MAT_B;
      expected_q.push_back(acc);
      acc.addr  = elem_addr(base_c, ri, cj);
      acc.sel   = MAT_C;
      acc.last  = 1'b1;
      acc.eot   = is_last;
      expected_q.push_back(acc);

      points++;
      if (is_last) begin
        done = 1'b1;
        traces++;
      end else if (inner + 1 < leaf) begin
        inner++;
      end else begin
        inner = 0;
        if (col + 1 < leaf) begin
          col++;
        end else begin
          col = 0;
          if (row + 1 < leaf) begin
            row++;
          end else begin
            row = 0;
            tile_idx++;
          end
        end
      end
      return 3;
    endfunction

    function void check_access(logic [AddrW-1:0] addr, logic [SelW-1:0] sel, logic last,
                               logic eot, logic unsup);
      access_t exp;
      accesses++;
      if (expected_q.size() == 0) begin
        $error("unexpected transaction: byte_address %h matrix_select %0d", addr, sel);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (addr !== exp.addr) begin
        $error("byte_address: expected %h, actual %h", exp.addr, addr);
        errors++;
      end
      if (sel !== exp.sel) begin
        $error("matrix_select: expected %0d, actual %0d", exp.sel, sel);
        errors++;
      end
      if (last !== exp.last) begin
        $error("last_of_point: expected %0b, actual %0b", exp.last, last);
        errors++;
      end
      if (eot !== exp.eot) begin
        $error("end_of_trace: expected %0b, actual %0b", exp.eot, eot);
        errors++;
      end
      if (unsup !== exp.unsup) begin
        $error("unsupported_side: expected %0b, actual %0b", exp.unsup, unsup);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [AddrW-1:0]   cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic               restart_i   = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [AddrW-1:0]   byte_address_o;
  logic [SelW-1:0]    matrix_select_o;
  logic               last_of_point_o;
  logic               end_of_trace_o;
  logic               unsupported_side_o;

  trace_scoreboard    sb;
  int unsigned        idle_pct     = 0;
  int unsigned        stall_pct    = 0;
  int unsigned        cycle_count  = 0;
  int unsigned        requests     = 0;
  int unsigned        side_changes = 0;

  recursive_matmul_address_trace u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .restart_i          (restart_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .byte_address_o     (byte_address_o),
    .matrix_select_o    (matrix_select_o),
    .last_of_point_o    (last_of_point_o),
    .end_of_trace_o     (end_of_trace_o),
    .unsupported_side_o (unsupported_side_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_access(byte_address_o, matrix_select_o, last_of_point_o, end_of_trace_o,
                      unsupported_side_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(input bit restart, output int unsigned n_res);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    n_res = sb.note_request(restart);
    requests++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [AddrW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    if (idx == RegSide) side_changes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_run(input bit restart, input int unsigned count);
    int unsigned n_res;
    repeat (count) send_request(restart, n_res);
  endtask

  function automatic logic [AddrW-1:0] random_base();
    case ($urandom_range(3))
      0:       return '0;
      1:       return 32'hFFFF_FFFF - $urandom_range(255);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [SideW-1:0] random_side();
    case ($urandom_range(7))
      0, 1, 2: return SideW'($urandom_range(3, 1));
      3:       return SideW'($urandom_range(8, 4));
      4:       return SideW'($urandom_range(40, 9));
      5:       return SideW'(MaxSide);
      6:       return SideW'($urandom_range(2046, MaxSide + 1));
      default: return '1;
    endcase
  endfunction

  task automatic random_segment(input int unsigned target);
    int unsigned produced;
    int unsigned n_res;
    bit          rs;
    drain();
    write_reg(RegSide, ($urandom() & 32'hFFFF_F800) | AddrW'(random_side()));
    write_reg(RegABase, random_base());
    write_reg(RegBBase, random_base());
    write_reg(RegCBase, random_base());
    if ($urandom_range(3) == 0) write_reg(RegNone, $urandom());
    produced = 0;
    while (produced < target) begin
      rs = sb.trace_done() ? ($urandom_range(3) != 0) : ($urandom_range(24) == 0);
      send_request(rs, n_res);
      if (n_res != 0) produced++;
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_run(1'b0, 2);
    send_run(1'b1, 1);

    drain();
    write_reg(RegSide, 32'hFFFF_F801);
    write_reg(RegABase, 32'hFFFF_FFFF);
    write_reg(RegBBase, 32'h0000_0000);
    write_reg(RegCBase, 32'hFFFF_FFFC);
    send_run(1'b0, 2);
    send_run(1'b1, 1);

    drain();
    write_reg(RegSide, 32'h0000_0000);
    send_run(1'b0, 1);
    send_run(1'b1, 1);

    drain();
    write_reg(RegSide, 32'hFFFF_FFFF);
    write_reg(RegABase, 32'h8000_0000);
    send_run(1'b0, 2);

    drain();
    write_reg(RegSide, 32'd9);
    send_run(1'b0, 2);

    drain();
    write_reg(RegSide, AddrW'(MaxSide));
    write_reg(RegBBase, 32'h7FFF_FFF0);
    send_run(1'b0, 2);

    drain();
    write_reg(RegSide, 32'd2);
    send_run(1'b0, 3);
    drain();
    write_reg(RegNone, $urandom());
    send_run(1'b0, 1);

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 59; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      random_segment(SegmentItems);
      random_segment(SegmentItems);
    end

    drain();
    $display("Summary: %0d requests over %0d side settings, %0d points, %0d accesses checked",
             requests, side_changes, sb.points, sb.accesses);
    $display("Summary: %0d complete traces reached their final access", sb.traces);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
